// File: design/sdet_pkg.sv
`default_nettype none

package sdet_pkg;

    localparam int MODULES_DEFAULT = 5;
    localparam int QUEUE_DEPTH     = 2;
    localparam int BYTE_W          = 8;
    localparam int ID_W            = 8;
    localparam int MODULE_W        = 4;

    typedef struct packed {
        logic [BYTE_W-1:0]   fell;
        logic [MODULE_W-1:0] module_num;
        logic                odd;
        logic                done;
    } sdet_entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } sdet_q_status_t;

endpackage

`default_nettype wire

// File: design/sdet_front.sv
`default_nettype none

module sdet_front #(
    parameter int MODULES = sdet_pkg::MODULES_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [sdet_pkg::BYTE_W-1:0] data_byte,
    output logic                            full,
    input  wire sdet_pkg::sdet_q_status_t   q_status,
    output logic                            q_push,
    output sdet_pkg::sdet_entry_t           q_entry
);

    localparam int DUMP_BYTES = 2 * MODULES;
    localparam int PW         = $clog2(DUMP_BYTES);

    logic [PW-1:0]                 pos_reg;
    logic [PW-1:0]                 pos_next;
    logic [sdet_pkg::BYTE_W-1:0]   prev_reg [DUMP_BYTES];
    logic                          accept;
    logic                          done;
    logic [sdet_pkg::BYTE_W-1:0]   fell;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;
    assign done   = (pos_reg == PW'(DUMP_BYTES - 1));
    assign fell   = prev_reg[pos_reg] & ~data_byte;

    always_comb
    begin
        if (done)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    assign q_push             = accept && ((fell != '0) || done);
    assign q_entry.fell       = fell;
    assign q_entry.module_num = sdet_pkg::MODULE_W'(pos_reg >> 1);
    assign q_entry.odd        = pos_reg[0];
    assign q_entry.done       = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < DUMP_BYTES; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            pos_reg           <= pos_next;
            prev_reg[pos_reg] <= data_byte;
        end
    end

endmodule

`default_nettype wire

// File: design/sdet_queue.sv
`default_nettype none

module sdet_queue #(
    parameter int DEPTH = sdet_pkg::QUEUE_DEPTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire sdet_pkg::sdet_entry_t  wr_entry,
    input  wire logic                   rd_en,
    output sdet_pkg::sdet_entry_t       rd_entry,
    output sdet_pkg::sdet_q_status_t    status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sdet_pkg::sdet_entry_t mem_reg [DEPTH];
    logic [AW-1:0]         wr_ptr_reg;
    logic [AW-1:0]         rd_ptr_reg;
    logic [CW-1:0]         count_reg;
    logic [AW-1:0]         wr_ptr_next;
    logic [AW-1:0]         rd_ptr_next;
    logic [CW-1:0]         count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CW'(DEPTH));
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && status.valid;
    assign rd_entry     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

// File: design/sdet_back.sv
`default_nettype none

module sdet_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sdet_pkg::sdet_q_status_t   q_status,
    input  wire sdet_pkg::sdet_entry_t      q_entry,
    output logic                            q_pop,
    input  wire logic                       pop,
    output logic                            empty,
    output logic                            has_sensor,
    output logic [sdet_pkg::ID_W-1:0]       sensor_num,
    output logic                            dump_complete,
    output logic                            last
);

    logic                                busy_reg;
    logic                                busy_next;
    logic [sdet_pkg::BYTE_W-1:0]         mask_reg;
    logic [sdet_pkg::BYTE_W-1:0]         mask_next;
    logic [sdet_pkg::MODULE_W-1:0]       module_reg;
    logic                                odd_reg;
    logic                                done_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                out_has_reg;
    logic [sdet_pkg::ID_W-1:0]           out_id_reg;
    logic                                out_done_reg;
    logic                                out_last_reg;
    logic                                advance;
    logic                                emit_has;
    logic [sdet_pkg::ID_W-1:0]           emit_id;
    logic                                emit_last;
    logic [2:0]                          low_idx;
    logic [sdet_pkg::BYTE_W-1:0]         mask_clr;
    logic                                finishing;

    // lowest set bit of the working mask
    always_comb
    begin
        low_idx = '0;
        for (int i = sdet_pkg::BYTE_W - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_idx = 3'(i);
            end
        end
    end

    assign mask_clr  = mask_reg & (mask_reg - 1'b1);
    assign emit_has  = (mask_reg != '0);
    assign emit_id   = emit_has ? {module_reg, odd_reg, ~low_idx} : '0;
    assign emit_last = emit_has ? (mask_clr == '0) : 1'b1;

    assign advance   = !out_valid_reg || pop;
    assign finishing = busy_reg && advance && emit_last;
    assign q_pop     = q_status.valid && (!busy_reg || finishing);

    always_comb
    begin
        busy_next = busy_reg;
        mask_next = mask_reg;
        if (busy_reg && advance)
        begin
            mask_next = mask_clr;
        end
        if (q_pop)
        begin
            busy_next = 1'b1;
            mask_next = q_entry.fell;
        end
        else if (finishing)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        if (q_pop)
        begin
            module_reg <= q_entry.module_num;
            odd_reg    <= q_entry.odd;
            done_reg   <= q_entry.done;
        end
        if (busy_reg && advance)
        begin
            out_has_reg  <= emit_has;
            out_id_reg   <= emit_id;
            out_done_reg <= done_reg;
            out_last_reg <= emit_last;
        end
    end

    assign empty         = !out_valid_reg;
    assign has_sensor    = out_has_reg;
    assign sensor_num    = out_id_reg;
    assign dump_complete = out_done_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire

// File: design/sensor_dump_edge_detector_top.sv
// path: an accepted byte with falling bits, or a dump's last byte, passes the queue, working mask, output registers
// throughput: one byte per cycle while the queue is not full; a byte gives one id per falling bit
// a 2-entry queue between the byte classifier and the id serializer decouples them
// reset: dump position returns to 0, stored dump is cleared to zero, queue and results empty
`default_nettype none

module sensor_dump_edge_detector_top #(
    parameter int MODULES = sdet_pkg::MODULES_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [sdet_pkg::BYTE_W-1:0] data_byte,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            has_sensor,
    output logic [sdet_pkg::ID_W-1:0]       sensor_num,
    output logic                            dump_complete,
    output logic                            last
);

    sdet_pkg::sdet_q_status_t q_status;
    sdet_pkg::sdet_entry_t    wr_entry;
    sdet_pkg::sdet_entry_t    rd_entry;
    logic                     q_push;
    logic                     q_pop;

    sdet_front #(
        .MODULES (MODULES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .full      (full),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_entry   (wr_entry)
    );

    sdet_queue #(
        .DEPTH (sdet_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (wr_entry),
        .rd_en    (q_pop),
        .rd_entry (rd_entry),
        .status   (q_status)
    );

    sdet_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_entry       (rd_entry),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .has_sensor    (has_sensor),
        .sensor_num    (sensor_num),
        .dump_complete (dump_complete),
        .last          (last)
    );

endmodule

`default_nettype wire

// File: design/sdet_checker.sv
`default_nettype none

module sdet_checker #(
    parameter int MODULES = sdet_pkg::MODULES_DEFAULT
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        empty,
    input wire logic                        pop,
    input wire logic                        has_sensor,
    input wire logic [sdet_pkg::ID_W-1:0]   sensor_num,
    input wire logic                        dump_complete,
    input wire logic                        last
);

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(sensor_num) && $stable(last))
        else $error("result changed while waiting");

    // an empty-id result only closes a dump
    a_no_sensor: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !has_sensor |-> last && dump_complete && (sensor_num == '0))
        else $error("bad result without sensor");

    // module number stays within the dump
    a_module: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && has_sensor |-> ({1'b0, sensor_num[7:4]} < 5'(MODULES)))
        else $error("module number out of range");

    // ids of one byte share module and half, in falling sensor order
    a_group: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !last |=> empty ||
            ((sensor_num[7:3] == $past(sensor_num[7:3])) &&
             (sensor_num[2:0] < $past(sensor_num[2:0])) &&
             (dump_complete == $past(dump_complete)) && has_sensor))
        else $error("ids of one byte out of order");

endmodule

bind sensor_dump_edge_detector_top sdet_checker #(
    .MODULES (MODULES)
) u_sdet_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .has_sensor    (has_sensor),
    .sensor_num    (sensor_num),
    .dump_complete (dump_complete),
    .last          (last)
);

`default_nettype wire
